// ===== sv/upsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsg_pkg
// Shared widths, microcode layout and control store of the prime spiral block.
// ----------------------------------------------------------------------------
package upsg_pkg;

  localparam int INDEX_BITS = 16;
  localparam int CNT_W      = INDEX_BITS + 1;
  localparam int MAX_W      = 16;
  localparam int CMP_W      = (CNT_W > MAX_W) ? CNT_W : MAX_W;
  localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(1000);

  localparam int DIV_W     = (INDEX_BITS + 1) / 2 + 1;
  localparam int SQ_W      = 2 * DIV_W;
  localparam int DIV_STEPS = (INDEX_BITS + 1) / 2;
  localparam int QUO_W     = 2 * DIV_STEPS;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  localparam int POS_W = 9;
  localparam int DIR_W = 2;
  localparam int RUN_W = 9;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t S_IDLE  = PC_W'(0);
  localparam pc_t S_SMALL = PC_W'(1);
  localparam pc_t S_TWO3  = PC_W'(2);
  localparam pc_t S_EVEN  = PC_W'(3);
  localparam pc_t S_SQ    = PC_W'(4);
  localparam pc_t S_DIV   = PC_W'(5);
  localparam pc_t S_NEXTD = PC_W'(6);
  localparam pc_t S_LOOP  = PC_W'(7);
  localparam pc_t S_EMIT  = PC_W'(8);
  localparam pc_t S_ADV   = PC_W'(9);
  localparam pc_t S_LAST  = S_ADV;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SET_D,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_D_ADD2,
    OP_EMIT,
    OP_ADVANCE
  } op_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_GO,
    C_LT2,
    C_LE3,
    C_EVEN,
    C_SQ_GT,
    C_DIV_MORE,
    C_REM_ZERO,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic  take;
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic go;
    logic lt2;
    logic le3;
    logic even;
    logic sq_gt;
    logic div_more;
    logic rem_zero;
    logic out_busy;
  } dp_status_t;

  function automatic uword_t ucode(input pc_t addr);
    uword_t w;
    w = '{take: 1'b0, op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
    unique case (addr)
      S_IDLE:  w = '{take: 1'b1, op: OP_NOP,      cond: C_NO_GO,    target: S_IDLE};
      S_SMALL: w = '{take: 1'b0, op: OP_NOP,      cond: C_LT2,      target: S_ADV};
      S_TWO3:  w = '{take: 1'b0, op: OP_SET_D,    cond: C_LE3,      target: S_EMIT};
      S_EVEN:  w = '{take: 1'b0, op: OP_NOP,      cond: C_EVEN,     target: S_ADV};
      S_SQ:    w = '{take: 1'b0, op: OP_DIV_INIT, cond: C_SQ_GT,    target: S_EMIT};
      S_DIV:   w = '{take: 1'b0, op: OP_DIV_STEP, cond: C_DIV_MORE, target: S_DIV};
      S_NEXTD: w = '{take: 1'b0, op: OP_D_ADD2,   cond: C_REM_ZERO, target: S_ADV};
      S_LOOP:  w = '{take: 1'b0, op: OP_NOP,      cond: C_ALWAYS,   target: S_SQ};
      S_EMIT:  w = '{take: 1'b0, op: OP_EMIT,     cond: C_OUT_BUSY, target: S_EMIT};
      S_ADV:   w = '{take: 1'b0, op: OP_ADVANCE,  cond: C_ALWAYS,   target: S_IDLE};
      default: w = '{take: 1'b0, op: OP_NOP,      cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/upsg_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsg_sequencer
// Step counter over the control store with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module upsg_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  upsg_pkg::dp_status_t  status,
  output upsg_pkg::uword_t      ctrl
);

  upsg_pkg::pc_t pc;
  upsg_pkg::pc_t pc_next;
  logic          hit;

  assign ctrl = upsg_pkg::ucode(pc);

  always_comb begin
    unique case (ctrl.cond)
      upsg_pkg::C_ALWAYS:   hit = 1'b1;
      upsg_pkg::C_NO_GO:    hit = !status.go;
      upsg_pkg::C_LT2:      hit = status.lt2;
      upsg_pkg::C_LE3:      hit = status.le3;
      upsg_pkg::C_EVEN:     hit = status.even;
      upsg_pkg::C_SQ_GT:    hit = status.sq_gt;
      upsg_pkg::C_DIV_MORE: hit = status.div_more;
      upsg_pkg::C_REM_ZERO: hit = status.rem_zero;
      upsg_pkg::C_OUT_BUSY: hit = status.out_busy;
      default:              hit = 1'b1;
    endcase
  end

  assign pc_next = hit ? ctrl.target : pc + upsg_pkg::PC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= upsg_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef SYNTHESIS
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= upsg_pkg::S_LAST)
    else $error("step counter left the program");
`endif

endmodule

// ===== sv/upsg_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsg_walker
// Square spiral walker: position, heading, run length and turn parity.
// ----------------------------------------------------------------------------
module upsg_walker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  output logic signed [upsg_pkg::POS_W-1:0]   pos_x,
  output logic signed [upsg_pkg::POS_W-1:0]   pos_y
);

  logic signed [upsg_pkg::DIR_W-1:0] dir_x;
  logic signed [upsg_pkg::DIR_W-1:0] dir_y;
  logic [upsg_pkg::RUN_W-1:0]        run_length;
  logic [upsg_pkg::RUN_W-1:0]        steps_taken;
  logic                              turn_parity;
  logic [upsg_pkg::RUN_W-1:0]        steps_next;
  logic signed [upsg_pkg::POS_W-1:0] step_x;
  logic signed [upsg_pkg::POS_W-1:0] step_y;

  assign step_x     = {{(upsg_pkg::POS_W - upsg_pkg::DIR_W){dir_x[upsg_pkg::DIR_W-1]}}, dir_x};
  assign step_y     = {{(upsg_pkg::POS_W - upsg_pkg::DIR_W){dir_y[upsg_pkg::DIR_W-1]}}, dir_y};
  assign steps_next = steps_taken + upsg_pkg::RUN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= '0;
      pos_y       <= '0;
      dir_x       <= upsg_pkg::DIR_W'(1);
      dir_y       <= '0;
      run_length  <= upsg_pkg::RUN_W'(1);
      steps_taken <= '0;
      turn_parity <= 1'b0;
    end else if (advance) begin
      pos_x <= pos_x + step_x;
      pos_y <= pos_y + step_y;
      if (steps_next == run_length) begin
        // quarter turn counter-clockwise
        steps_taken <= '0;
        dir_x       <= '0 - dir_y;
        dir_y       <= dir_x;
        turn_parity <= !turn_parity;
        if (turn_parity) begin
          run_length <= run_length + upsg_pkg::RUN_W'(1);
        end
      end else begin
        steps_taken <= steps_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_steps_below_run: assert property (@(posedge clk) disable iff (rst)
    steps_taken < run_length)
    else $error("walker step count reached run length");
`endif

endmodule

// ===== sv/upsg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsg_datapath
// Index register, trial divisor, two-bit-per-cycle remainder unit, limit
// register and result register.
// ----------------------------------------------------------------------------
module upsg_datapath (
  input  logic                                     clk,
  input  logic                                     rst,
  input  upsg_pkg::op_t                            op,
  input  logic                                     in_valid,
  input  logic                                     tick,
  input  logic                                     cfg_we,
  input  logic [upsg_pkg::MAX_W-1:0]               cfg_data,
  input  logic signed [upsg_pkg::POS_W-1:0]        pos_x,
  input  logic signed [upsg_pkg::POS_W-1:0]        pos_y,
  input  logic                                     out_ready,
  output upsg_pkg::dp_status_t                     status,
  output logic                                     out_valid,
  output logic [upsg_pkg::INDEX_BITS-1:0]          prime_index,
  output logic signed [upsg_pkg::POS_W-1:0]        grid_x,
  output logic signed [upsg_pkg::POS_W-1:0]        grid_y
);

  logic [upsg_pkg::MAX_W-1:0]      max_count;
  logic [upsg_pkg::CNT_W-1:0]      current_index;
  logic [upsg_pkg::INDEX_BITS-1:0] n;
  logic [upsg_pkg::DIV_W-1:0]      divisor;
  logic [upsg_pkg::DIV_W-1:0]      rem;
  logic [upsg_pkg::QUO_W-1:0]      quo;
  logic [upsg_pkg::STEP_W-1:0]     step_cnt;
  logic [upsg_pkg::SQ_W-1:0]       d_sq;
  logic [upsg_pkg::DIV_W:0]        t1;
  logic [upsg_pkg::DIV_W:0]        t2;
  logic [upsg_pkg::DIV_W-1:0]      rem_next;
  logic                            past;
  logic                            out_busy;
  logic                            load_out;

  assign n        = current_index[upsg_pkg::INDEX_BITS-1:0];
  assign past     = (upsg_pkg::CMP_W'(current_index) > upsg_pkg::CMP_W'(max_count))
                    || current_index[upsg_pkg::INDEX_BITS];
  assign d_sq     = upsg_pkg::SQ_W'(divisor) * upsg_pkg::SQ_W'(divisor);
  assign out_busy = out_valid && !out_ready;
  assign load_out = (op == upsg_pkg::OP_EMIT) && !out_busy;

  // two restoring remainder steps
  always_comb begin
    t1 = {rem, quo[upsg_pkg::QUO_W-1]};
    if (t1 >= {1'b0, divisor}) begin
      t1 = t1 - {1'b0, divisor};
    end
    t2 = {t1[upsg_pkg::DIV_W-1:0], quo[upsg_pkg::QUO_W-2]};
    if (t2 >= {1'b0, divisor}) begin
      t2 = t2 - {1'b0, divisor};
    end
    rem_next = t2[upsg_pkg::DIV_W-1:0];
  end

  always_comb begin
    status.go       = in_valid && tick && !past;
    status.lt2      = current_index < upsg_pkg::CNT_W'(2);
    status.le3      = (current_index == upsg_pkg::CNT_W'(2))
                      || (current_index == upsg_pkg::CNT_W'(3));
    status.even     = !current_index[0];
    status.sq_gt    = d_sq > upsg_pkg::SQ_W'(n);
    status.div_more = step_cnt != upsg_pkg::STEP_LAST;
    status.rem_zero = rem == '0;
    status.out_busy = out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count     <= upsg_pkg::MAX_RESET;
      current_index <= upsg_pkg::CNT_W'(1);
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_count <= cfg_data;
      end
      if (op == upsg_pkg::OP_ADVANCE) begin
        current_index <= current_index + upsg_pkg::CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      upsg_pkg::OP_SET_D: begin
        divisor <= upsg_pkg::DIV_W'(3);
      end
      upsg_pkg::OP_DIV_INIT: begin
        rem      <= '0;
        quo      <= upsg_pkg::QUO_W'(n);
        step_cnt <= '0;
      end
      upsg_pkg::OP_DIV_STEP: begin
        rem      <= rem_next;
        quo      <= {quo[upsg_pkg::QUO_W-3:0], 2'b00};
        step_cnt <= step_cnt + upsg_pkg::STEP_W'(1);
      end
      upsg_pkg::OP_D_ADD2: begin
        divisor <= divisor + upsg_pkg::DIV_W'(2);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      prime_index <= n;
      grid_x      <= pos_x;
      grid_y      <= pos_y;
    end
  end

`ifndef SYNTHESIS
  a_result_index_prime_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> prime_index >= upsg_pkg::INDEX_BITS'(2))
    else $error("result index below two");

  a_divisor_odd: assert property (@(posedge clk) disable iff (rst)
    (op == upsg_pkg::OP_DIV_STEP) |-> (divisor[0] && divisor >= upsg_pkg::DIV_W'(3)))
    else $error("trial divisor not an odd value of three or more");
`endif

endmodule

// ===== sv/ulam_prime_spiral_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulam_prime_spiral_generator
// Each tick request examines the next index from 1 up to max_count; a prime
// index is returned with its square-spiral grid position. Index one is passed
// over, indices two and three are emitted and other even indices are passed
// over; an odd index is tested against odd trial divisors from three upward
// until one divides it (composite) or its square exceeds it (prime). At most
// 127 divisors are tried for 16-bit indices; each divisor runs the remainder
// unit at two dividend bits per cycle plus 3 control steps. A prime
// also waits in its emit step for as long as the previous result is held. A
// tick of zero or one past the limit is taken and gives nothing.
// ----------------------------------------------------------------------------
module ulam_prime_spiral_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [upsg_pkg::MAX_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                tick,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [upsg_pkg::INDEX_BITS-1:0]     prime_index,
  output logic signed [upsg_pkg::POS_W-1:0]   grid_x,
  output logic signed [upsg_pkg::POS_W-1:0]   grid_y
);

  upsg_pkg::uword_t                  ctrl;
  upsg_pkg::dp_status_t              status;
  logic signed [upsg_pkg::POS_W-1:0] pos_x;
  logic signed [upsg_pkg::POS_W-1:0] pos_y;
  logic                              advance;

  assign in_ready = ctrl.take;
  assign advance  = ctrl.op == upsg_pkg::OP_ADVANCE;

  upsg_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  upsg_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .pos_x   (pos_x),
    .pos_y   (pos_y)
  );

  upsg_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (ctrl.op),
    .in_valid    (in_valid),
    .tick        (tick),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .out_ready   (out_ready),
    .status      (status),
    .out_valid   (out_valid),
    .prime_index (prime_index),
    .grid_x      (grid_x),
    .grid_y      (grid_y)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the prime spiral generator. A local model of the
// spiral walker and trial-division prime test predicts the index and grid
// position of every prime tick, and a monitor compares each result in order.
// Covers limit writes (zero, one, full range, random), stop and resume at the
// limit, ignored ticks, long output back-pressure and random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT  = 5000000;
  localparam int DRAIN_CYCLES = 1500;
  localparam int LONG_HOLD    = 3000;

  typedef struct {
    logic [upsg_pkg::CNT_W-1:0]        index;
    logic signed [upsg_pkg::POS_W-1:0] px;
    logic signed [upsg_pkg::POS_W-1:0] py;
    logic signed [upsg_pkg::DIR_W-1:0] dx;
    logic signed [upsg_pkg::DIR_W-1:0] dy;
    logic [upsg_pkg::RUN_W-1:0]        run_len;
    logic [upsg_pkg::RUN_W-1:0]        steps;
    logic                              parity;
    logic [upsg_pkg::MAX_W-1:0]        limit;
  } spiral_state_t;

  typedef struct {
    logic [upsg_pkg::INDEX_BITS-1:0]   idx;
    logic signed [upsg_pkg::POS_W-1:0] x;
    logic signed [upsg_pkg::POS_W-1:0] y;
  } prime_hit_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [upsg_pkg::MAX_W-1:0]        cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              tick = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [upsg_pkg::INDEX_BITS-1:0]   prime_index;
  logic signed [upsg_pkg::POS_W-1:0] grid_x;
  logic signed [upsg_pkg::POS_W-1:0] grid_y;

  spiral_state_t spiral;
  prime_hit_t    pending_primes[$];
  prime_hit_t    oldest;
  int            error_count = 0;
  int            cycle_count = 0;
  int            examined_count = 0;
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;
  bit            hold_pending = 1'b0;
  int            rx_stall_left = 0;

  ulam_prime_spiral_generator dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .tick       (tick),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prime_index(prime_index),
    .grid_x     (grid_x),
    .grid_y     (grid_y)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_prime_number(input int unsigned n);
    if (n < 2) return 1'b0;
    for (int unsigned d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void reset_spiral();
    spiral.index   = upsg_pkg::CNT_W'(1);
    spiral.px      = '0;
    spiral.py      = '0;
    spiral.dx      = upsg_pkg::DIR_W'(1);
    spiral.dy      = '0;
    spiral.run_len = upsg_pkg::RUN_W'(1);
    spiral.steps   = '0;
    spiral.parity  = 1'b0;
    spiral.limit   = upsg_pkg::MAX_RESET;
  endfunction

  function automatic void step_spiral(input bit t);
    prime_hit_t                        hit;
    logic signed [upsg_pkg::DIR_W-1:0] old_dx;
    if (!t) return;
    if (spiral.index > upsg_pkg::CNT_W'(spiral.limit) ||
        spiral.index > upsg_pkg::CNT_W'({upsg_pkg::INDEX_BITS{1'b1}})) return;
    examined_count++;
    if (is_prime_number(int'(spiral.index))) begin
      hit.idx = spiral.index[upsg_pkg::INDEX_BITS-1:0];
      hit.x   = spiral.px;
      hit.y   = spiral.py;
      pending_primes.push_back(hit);
    end
    spiral.px    = spiral.px + spiral.dx;
    spiral.py    = spiral.py + spiral.dy;
    spiral.steps = spiral.steps + upsg_pkg::RUN_W'(1);
    if (spiral.steps == spiral.run_len) begin
      // quarter turn counter-clockwise
      spiral.steps  = '0;
      old_dx        = spiral.dx;
      spiral.dx     = -spiral.dy;
      spiral.dy     = old_dx;
      spiral.parity = ~spiral.parity;
      if (!spiral.parity) spiral.run_len = spiral.run_len + upsg_pkg::RUN_W'(1);
    end
    spiral.index = spiral.index + upsg_pkg::CNT_W'(1);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic send_tick(input bit t);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick     <= t;
    do @(posedge clk); while (!in_ready);
    step_spiral(t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_primes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max(input logic [upsg_pkg::MAX_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    spiral.limit = value;
    @(posedge clk);
  endtask

  task automatic test_zero_limit();
    write_max('0);
    repeat (4) send_tick(1'b1);
    send_tick(1'b0);
    wait_drained();
  endtask

  task automatic test_limit_one();
    write_max(upsg_pkg::MAX_W'(1));
    repeat (3) send_tick(1'b1);
    wait_drained();
  endtask

  task automatic test_first_primes();
    write_max({upsg_pkg::MAX_W{1'b1}});
    send_tick(1'b0);
    repeat (6) send_tick(1'b1);
    send_tick(1'b0);
    repeat (8) send_tick(1'b1);
    wait_drained();
  endtask

  task automatic test_stop_resume();
    write_max(spiral.index[upsg_pkg::MAX_W-1:0] - upsg_pkg::MAX_W'(1));
    repeat (4) send_tick(1'b1);
    wait_drained();
    write_max(spiral.index[upsg_pkg::MAX_W-1:0] + upsg_pkg::MAX_W'(3));
    repeat (6) send_tick(1'b1);
    wait_drained();
    write_max({upsg_pkg::MAX_W{1'b1}});
  endtask

  task automatic test_backpressure();
    hold_pending = 1'b1;
    repeat (40) send_tick(1'b1);
    wait_drained();
  endtask

  task automatic test_random_walk();
    int start_count;
    int tries;
    for (int phase = 0; phase < 5; phase++) begin
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      case (phase)
        0: write_max({upsg_pkg::MAX_W{1'b1}});
        1: write_max(upsg_pkg::MAX_W'($urandom_range(0, 65535)));
        2: write_max(upsg_pkg::MAX_W'(1000));
        default: write_max(spiral.index[upsg_pkg::MAX_W-1:0] +
                           upsg_pkg::MAX_W'($urandom_range(40, 120)));
      endcase
      start_count = examined_count;
      tries = 0;
      while (examined_count - start_count < 76 && tries < 92) begin
        send_tick($urandom_range(0, 7) != 0);
        tries++;
      end
      wait_drained();
    end
  endtask

  task automatic test_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_max({upsg_pkg::MAX_W{1'b1}});
    repeat (60) send_tick(1'b1);
    wait_drained();
  endtask

  // output side: random stall bursts and the long hold
  always @(posedge clk) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      rx_stall_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_on && $urandom_range(0, 5) == 0) rx_stall_left = $urandom_range(1, 17);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_primes.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d", prime_index));
      end else begin
        oldest = pending_primes.pop_front();
        if (prime_index !== oldest.idx)
          report_mismatch($sformatf("prime_index got %0d want %0d", prime_index, oldest.idx));
        if (grid_x !== oldest.x)
          report_mismatch($sformatf("grid_x of %0d got %0d want %0d", oldest.idx, grid_x,
                                    oldest.x));
        if (grid_y !== oldest.y)
          report_mismatch($sformatf("grid_y of %0d got %0d want %0d", oldest.idx, grid_y,
                                    oldest.y));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    reset_spiral();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_limit();
    test_limit_one();
    test_first_primes();
    test_stop_resume();
    test_backpressure();
    test_random_walk();
    test_no_idle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/upsg_pkg.sv
sv/upsg_sequencer.sv
sv/upsg_walker.sv
sv/upsg_datapath.sv
sv/ulam_prime_spiral_generator.sv
tb/sv/tb_top.sv
